// ===== hdl/slave_setpoint_ramp_sequencer_assert.svh =====
// Assertion macros for the setpoint ramp sequencer.
`ifndef SLAVE_SETPOINT_RAMP_SEQUENCER_ASSERT_SVH
`define SLAVE_SETPOINT_RAMP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ssrs: assertion failed");

// Next-cycle implication, checked out of reset.
`define SSRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ssrs: assertion failed");

`endif

// ===== hdl/ssrs_pkg.sv =====
// Shared types and constants of the setpoint ramp sequencer.
package ssrs_pkg;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_SETPOINT = 3'd2,
        OP_SET_ALL  = 3'd3,
        OP_STATUS   = 3'd4,
        OP_UNKNOWN  = 3'd5,
        OP_TICK     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RUNNING = 2'd1,
        ST_STOPPED = 2'd2,
        ST_ERROR   = 2'd3
    } status_t;

    localparam logic KIND_FEEDBACK = 1'b0;
    localparam logic KIND_CONTROL  = 1'b1;

    localparam logic [2:0] CFG_RAMP_STEP    = 3'd0;
    localparam logic [2:0] CFG_STOP_STEP    = 3'd1;
    localparam logic [2:0] CFG_MAX_SETPOINT = 3'd2;
    localparam logic [2:0] CFG_MAX_FEEDBACK = 3'd3;
    localparam logic [2:0] CFG_STOP_HOLD    = 3'd4;

    localparam logic [9:0]  RST_RAMP_STEP    = 10'd5;
    localparam logic [9:0]  RST_STOP_STEP    = 10'd1;
    localparam logic [9:0]  RST_MAX_SETPOINT = 10'd1000;
    localparam logic [9:0]  RST_MAX_FEEDBACK = 10'd900;
    localparam logic [15:0] RST_STOP_HOLD    = 16'd1000;

    localparam logic [15:0] STOP_COUNTDOWN = 16'hFFFF;

    // voltage scaling: adc * FB_MUL / FB_DIV
    localparam logic [10:0] FB_MUL = 11'd1617;
    localparam logic [23:0] FB_DIV = 24'd4095;

    localparam logic [3:0] LEN_SETPOINT = 4'd2;
    localparam logic [3:0] LEN_SET_ALL  = 4'd4;

    typedef struct packed {
        logic [9:0]  ramp_step;
        logic [9:0]  stop_step;
        logic [9:0]  max_setpoint;
        logic [9:0]  max_feedback;
        logic [15:0] stop_hold;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  frame_length;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [11:0] adc_sample;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [9:0]  volt;
        logic [9:0]  ramped;
        logic        drive;
        logic        clear;
        logic [11:0] adc;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== hdl/slave_setpoint_ramp_sequencer.sv =====
// Setpoint ramp sequencer: top level with input register, config registers, core and result queue.
//
// Input stream (s_*): one transaction per decoded command or millisecond
// tick; s_tuser carries the operation, s_tdata the frame length, payload
// bytes and ADC sample. Output stream (m_*): feedback frames and control
// updates; m_tuser is the result kind, m_tlast marks the last result of
// an input transaction. Registers are written through cfg_wr_en, cfg_index
// and cfg_wdata, only while the block is idle; user rule, not enforced.
//
// An accepted transaction lands in the input register and is processed
// there once the result queue has room; its results go into the queue,
// whose head drives m_*. Throughput: one result leaves per cycle while
// m_tready is high; a command yields at most one result and a tick one,
// or two when it also sends a feedback frame. The single output port and
// the four-entry result queue set this figure.
//
// Reset (aresetn low, synchronous) empties the input register and queue,
// loads the register defaults and sets the status to stopped. When the
// receiver stalls, the queue fills, processing holds once fewer than two
// slots are free, and s_tready drops after the input register is full.
module slave_setpoint_ramp_sequencer #(
    parameter int unsigned FEEDBACK_PERIOD = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // frame_length[3:0], payload_byte0..3 (8 each), adc_sample[11:0]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status_code[1:0], fb_voltage[9:0], ramped_setpoint[9:0],
                                   // drive_enable, regulator_clear, measured_adc[11:0], zero[3:0]
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,   // last_result
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    `include "slave_setpoint_ramp_sequencer_assert.svh"

    ssrs_pkg::cfg_t    cfg;
    ssrs_pkg::item_t   in_item_reg, in_item_next;
    logic              in_valid_reg, in_valid_next;
    ssrs_pkg::push_t   push;
    ssrs_pkg::result_t head;
    logic              room;
    logic              fire;
    logic              s_take;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_take || (in_valid_reg && !fire);
        in_item_next  = in_item_reg;
        if (s_take) begin
            in_item_next.operation    = s_tuser;
            in_item_next.frame_length = s_tdata[3:0];
            in_item_next.byte0        = s_tdata[11:4];
            in_item_next.byte1        = s_tdata[19:12];
            in_item_next.byte2        = s_tdata[27:20];
            in_item_next.byte3        = s_tdata[35:28];
            in_item_next.adc_sample   = s_tdata[47:36];
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    ssrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ssrs_core #(
        .FEEDBACK_PERIOD (FEEDBACK_PERIOD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .push    (push)
    );

    ssrs_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop_ready  (m_tready),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head)
    );

    assign m_tdata = {4'd0, head.adc, head.clear, head.drive, head.ramped, head.volt,
                      head.status};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // a feedback frame never drives or clears the regulator
    `SSRS_ASSERT_NOW(a_fb_no_drive, m_tvalid && (m_tuser == ssrs_pkg::KIND_FEEDBACK), (m_tdata[22] == 1'b0) && (m_tdata[23] == 1'b0))
    // drive and clear are exclusive
    `SSRS_ASSERT_NOW(a_drive_clear_excl, m_tvalid, !(m_tdata[22] && m_tdata[23]))
    // a control update always closes its transaction
    `SSRS_ASSERT_NOW(a_ctrl_last, m_tvalid && (m_tuser == ssrs_pkg::KIND_CONTROL), m_tlast)
    // anything pushed shows up on the output the next cycle
    `SSRS_ASSERT_NEXT(a_push_shows, push.count != 2'd0, m_tvalid)

endmodule

// ===== hdl/ssrs_cfg.sv =====
// Configuration register file with write decode.
module ssrs_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    output ssrs_pkg::cfg_t      cfg
);

    ssrs_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ssrs_pkg::CFG_RAMP_STEP:    cfg_next.ramp_step    = cfg_wdata[9:0];
                ssrs_pkg::CFG_STOP_STEP:    cfg_next.stop_step    = cfg_wdata[9:0];
                ssrs_pkg::CFG_MAX_SETPOINT: cfg_next.max_setpoint = cfg_wdata[9:0];
                ssrs_pkg::CFG_MAX_FEEDBACK: cfg_next.max_feedback = cfg_wdata[9:0];
                ssrs_pkg::CFG_STOP_HOLD:    cfg_next.stop_hold    = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_step    <= ssrs_pkg::RST_RAMP_STEP;
            cfg_reg.stop_step    <= ssrs_pkg::RST_STOP_STEP;
            cfg_reg.max_setpoint <= ssrs_pkg::RST_MAX_SETPOINT;
            cfg_reg.max_feedback <= ssrs_pkg::RST_MAX_FEEDBACK;
            cfg_reg.stop_hold    <= ssrs_pkg::RST_STOP_HOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/ssrs_volt.sv =====
// Feedback voltage scaling: floor(adc * 1617 / 4095), saturated.
module ssrs_volt (
    input  logic [11:0] adc,
    input  logic [9:0]  max_feedback,
    output logic [9:0]  volt
);

    logic [22:0] prod;
    logic [23:0] est_sum;
    logic [11:0] q_est;
    logic [23:0] rem;
    logic [11:0] quot;

    // 1/4095 ~ (1 + 2^-12) / 4096; the estimate is low by at most one
    assign prod    = 23'(adc) * 23'(ssrs_pkg::FB_MUL);
    assign est_sum = {1'b0, prod} + 24'(prod[22:12]);
    assign q_est   = est_sum[23:12];
    assign rem     = {1'b0, prod} - {q_est, 12'd0} + 24'(q_est);
    assign quot    = (rem >= ssrs_pkg::FB_DIV) ? q_est + 12'd1 : q_est;
    assign volt    = (quot > {2'b00, max_feedback}) ? max_feedback : quot[9:0];

endmodule

// ===== hdl/ssrs_core.sv =====
// Sequencer state and single-pass command/tick processing.
module ssrs_core #(
    parameter int unsigned FEEDBACK_PERIOD = 100
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  ssrs_pkg::item_t item,
    input  ssrs_pkg::cfg_t  cfg,
    output ssrs_pkg::push_t push
);

    // exact floor(n / FEEDBACK_PERIOD) for 17-bit n via reciprocal multiply
    localparam int unsigned DIV_L = $clog2(FEEDBACK_PERIOD);
    localparam int unsigned DIV_S = 17 + DIV_L;
    localparam longint unsigned DIV_R =
        ((64'd1 << DIV_S) + FEEDBACK_PERIOD - 1) / FEEDBACK_PERIOD;
    localparam logic [34:0] DIV_M = 35'(DIV_R);
    localparam logic [16:0] PERIOD_M1 = 17'(FEEDBACK_PERIOD - 1);

    logic             running_reg, running_next;
    logic             stop_reg, stop_next;
    logic [9:0]       target_reg, target_next;
    logic [9:0]       ramped_reg, ramped_next;
    logic [1:0]       status_reg, status_next;
    logic [15:0]      cd_reg, cd_next;
    logic [11:0]      adc_last_reg, adc_last_next;

    logic [9:0]       volt;
    logic [16:0]      div_a, div_b;
    logic [34:0]      prod_a, prod_b;
    logic             div_hit;
    logic [15:0]      sp_raw;
    logic [9:0]       sp_clamped;
    logic             take_sp;
    logic             cmd_fb, tick_fb, is_tick;
    logic             drive, clear;
    logic [1:0]       n_res;
    ssrs_pkg::result_t fb_res, ctrl_res;

    function automatic logic [9:0] approach(input logic [9:0] cur, input logic [9:0] tgt,
                                            input logic [9:0] step);
        logic [9:0] res;
        res = cur;
        if (cur < tgt) begin
            res = ((tgt - cur) > step) ? cur + step : tgt;
        end else if (cur > tgt) begin
            res = ((cur - tgt) > step) ? cur - step : tgt;
        end
        return res;
    endfunction

    ssrs_volt u_volt (
        .adc          (adc_last_reg),
        .max_feedback (cfg.max_feedback),
        .volt         (volt)
    );

    // new count c = cd-1 is a multiple of the period when floor((c+P)/P)
    // differs from floor((c+P-1)/P)
    assign div_a   = {1'b0, cd_reg} + PERIOD_M1;
    assign div_b   = div_a - 17'd1;
    assign prod_a  = 35'(div_a) * DIV_M;
    assign prod_b  = 35'(div_b) * DIV_M;
    assign div_hit = prod_a[34:DIV_S] != prod_b[34:DIV_S];

    always_comb begin
        sp_raw = (ssrs_pkg::op_t'(item.operation) == ssrs_pkg::OP_SET_ALL)
                 ? {item.byte2, item.byte3} : {item.byte0, item.byte1};
        sp_clamped = (sp_raw > {6'd0, cfg.max_setpoint}) ? cfg.max_setpoint : sp_raw[9:0];
    end

    always_comb begin
        running_next  = running_reg;
        stop_next     = stop_reg;
        target_next   = target_reg;
        ramped_next   = ramped_reg;
        status_next   = status_reg;
        cd_next       = cd_reg;
        adc_last_next = adc_last_reg;
        cmd_fb        = 1'b0;
        tick_fb       = 1'b0;
        is_tick       = 1'b0;
        take_sp       = 1'b0;
        drive         = 1'b0;
        clear         = 1'b0;

        unique case (ssrs_pkg::op_t'(item.operation))
            ssrs_pkg::OP_START: begin
                running_next = 1'b1;
                status_next  = ssrs_pkg::ST_RUNNING;
                cmd_fb       = 1'b1;
            end
            ssrs_pkg::OP_STOP: begin
                stop_next   = 1'b1;
                target_next = '0;
                cd_next     = ssrs_pkg::STOP_COUNTDOWN;
                status_next = ssrs_pkg::ST_STOPPED;
                cmd_fb      = 1'b1;
            end
            ssrs_pkg::OP_SETPOINT: take_sp = item.frame_length >= ssrs_pkg::LEN_SETPOINT;
            ssrs_pkg::OP_SET_ALL:  take_sp = item.frame_length >= ssrs_pkg::LEN_SET_ALL;
            ssrs_pkg::OP_STATUS:   cmd_fb = 1'b1;
            ssrs_pkg::OP_UNKNOWN: begin
                status_next = ssrs_pkg::ST_ERROR;
                cmd_fb      = 1'b1;
            end
            ssrs_pkg::OP_TICK: begin
                is_tick = 1'b1;
                if (cd_reg != 16'd0) begin
                    cd_next = cd_reg - 16'd1;
                    tick_fb = div_hit;
                end
                adc_last_next = item.adc_sample;
                if (running_reg) begin
                    if (stop_reg) begin
                        if (ramped_reg > cfg.stop_step) begin
                            ramped_next = ramped_reg - cfg.stop_step;
                        end else begin
                            ramped_next = '0;
                            stop_next   = 1'b0;
                            cd_next     = cfg.stop_hold;
                        end
                    end else begin
                        ramped_next = approach(ramped_reg, target_reg, cfg.ramp_step);
                    end
                    drive = ramped_next != 10'd0;
                    clear = ramped_next == 10'd0;
                end
            end
            default: ;
        endcase

        if (take_sp) begin
            target_next = sp_clamped;
            cmd_fb      = 1'b1;
            if (!running_reg) begin
                status_next = ssrs_pkg::ST_STOPPED;
            end else begin
                stop_next   = 1'b0;
                cd_next     = '0;
                status_next = ssrs_pkg::ST_RUNNING;
            end
        end
    end

    always_comb begin
        fb_res.kind   = ssrs_pkg::KIND_FEEDBACK;
        fb_res.status = status_next;
        fb_res.volt   = volt;
        fb_res.ramped = ramped_reg;
        fb_res.drive  = 1'b0;
        fb_res.clear  = 1'b0;
        fb_res.adc    = adc_last_reg;
        fb_res.last   = !is_tick;

        ctrl_res.kind   = ssrs_pkg::KIND_CONTROL;
        ctrl_res.status = status_reg;
        ctrl_res.volt   = '0;
        ctrl_res.ramped = ramped_next;
        ctrl_res.drive  = drive;
        ctrl_res.clear  = clear;
        ctrl_res.adc    = adc_last_next;
        ctrl_res.last   = 1'b1;

        if (is_tick) begin
            n_res = tick_fb ? 2'd2 : 2'd1;
        end else begin
            n_res = cmd_fb ? 2'd1 : 2'd0;
        end

        push.count = fire ? n_res : 2'd0;
        push.r0    = (is_tick && !tick_fb) ? ctrl_res : fb_res;
        push.r1    = ctrl_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            stop_reg     <= 1'b0;
            target_reg   <= '0;
            ramped_reg   <= '0;
            status_reg   <= ssrs_pkg::ST_STOPPED;
            cd_reg       <= '0;
            adc_last_reg <= '0;
        end else if (fire) begin
            running_reg  <= running_next;
            stop_reg     <= stop_next;
            target_reg   <= target_next;
            ramped_reg   <= ramped_next;
            status_reg   <= status_next;
            cd_reg       <= cd_next;
            adc_last_reg <= adc_last_next;
        end
    end

endmodule

// ===== hdl/ssrs_outq.sv =====
// Four-entry result queue, up to two pushes and one pop per cycle.
module ssrs_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssrs_pkg::push_t   push,
    input  logic              pop_ready,
    output logic              room,
    output logic              head_valid,
    output ssrs_pkg::result_t head
);

    ssrs_pkg::result_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign head_valid = count_reg != 3'd0;
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    // leave space for a two-result item regardless of the pop
    assign room       = count_reg <= 3'd2;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
